// ----- rtl/ltc_timecode_decoder_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the timecode decoder checker
// ----------------------------------------------------------------------------
`ifndef LTC_TIMECODE_DECODER_UNIT_MACROS_SVH
`define LTC_TIMECODE_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, off while reset is asserted
`define LTCD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("timecode decoder check failed");

// Next-cycle implication, off while reset is asserted
`define LTCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("timecode decoder check failed");

`endif

// ----- rtl/ltcd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ltcd_pkg
// Types and constants shared by the timecode decoder modules.
// ----------------------------------------------------------------------------
package ltcd_pkg;

	localparam int FRAME_BITS = 80;
	localparam int POS_W      = 7;
	localparam int SYNC_LSB   = 64;
	localparam int TICK_W     = 16;
	localparam int HOURS_W    = 6;
	localparam int MIN_W      = 7;
	localparam int SEC_W      = 7;
	localparam int FRM_W      = 6;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LONG_THRESHOLD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_KEY       = 1'd1;

	localparam logic [CFG_DATA_W-1:0] LONG_THRESHOLD_RST = 16'd78;
	localparam logic [CFG_DATA_W-1:0] SYNC_KEY_RST       = 16'd49148;

	typedef struct packed {
		logic [HOURS_W-1:0] hours;
		logic [MIN_W-1:0]   minutes;
		logic [SEC_W-1:0]   seconds;
		logic [FRM_W-1:0]   frames;
	} time_t;

	// one word handed from the front to the back
	typedef struct packed {
		logic  done;
		time_t t;
	} rec_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] long_threshold;
		logic [CFG_DATA_W-1:0] sync_key;
	} cfg_regs_t;

endpackage

`default_nettype wire

// ----- rtl/ltcd_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ltcd_in_if
// Edge interval channel: one interval word per handshake.
// ----------------------------------------------------------------------------
interface ltcd_in_if import ltcd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [TICK_W-1:0] interval_ticks;

	modport source (output valid, output interval_ticks, input ready);
	modport sink (input valid, input interval_ticks, output ready);
endinterface

`default_nettype wire

// ----- rtl/ltcd_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ltcd_out_if
// Result channel: decode flags and the stored timecode.
// ----------------------------------------------------------------------------
interface ltcd_out_if import ltcd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               frame_done;
	logic               time_updated;
	logic [HOURS_W-1:0] hours_now;
	logic [MIN_W-1:0]   minutes_now;
	logic [SEC_W-1:0]   seconds_now;
	logic [FRM_W-1:0]   frames_now;

	modport source (output valid, output frame_done, output time_updated,
		output hours_now, output minutes_now, output seconds_now,
		output frames_now, input ready);
	modport sink (input valid, input frame_done, input time_updated,
		input hours_now, input minutes_now, input seconds_now,
		input frames_now, output ready);
endinterface

`default_nettype wire

// ----- rtl/ltcd_cfg_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ltcd_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface ltcd_cfg_if import ltcd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/ltc_timecode_decoder_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ltc_timecode_decoder_unit
// Linear timecode decoder: edge intervals in, frame sync and timecode out.
//
// Channel   Dir  Payload                                   Handshake
// interval  in   interval_ticks[15:0]                      valid/ready
// result    out  frame_done, time_updated, h/m/s/f now     valid/ready
// cfg       in   index[0], data[15:0]                      valid/ready, ready high
//
// One interval word is taken every cycle while the queue is not full; each
// result passes through the queue write, ms conversion and window check.
// The stored time only moves when a frame's result leaves the window stage,
// so results come out strictly in order, one per interval word.
// Reset clears the frame, stored time and registers to their defaults.
// A stalled result holds; up to QUEUE_DEPTH words plus two stages buffer
// before interval.ready drops.
// ----------------------------------------------------------------------------
module ltc_timecode_decoder_unit import ltcd_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ltcd_in_if.sink    interval,
	ltcd_out_if.source result,
	ltcd_cfg_if.sink   cfg
);

	cfg_regs_t cfg_regs_q;
	logic      q_full, q_empty, q_push, q_pop;
	rec_t      push_rec, pop_rec;

	assign cfg.ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_regs_q.long_threshold <= LONG_THRESHOLD_RST;
			cfg_regs_q.sync_key       <= SYNC_KEY_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_LONG_THRESHOLD: cfg_regs_q.long_threshold <= cfg.data;
				REG_SYNC_KEY:       cfg_regs_q.sync_key       <= cfg.data;
				default:            ;
			endcase
		end
	end

	ltcd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.interval (interval),
		.cfg_regs (cfg_regs_q),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_rec    (push_rec)
	);

	ltcd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_rec (push_rec),
		.full     (q_full),
		.pop      (q_pop),
		.pop_rec  (pop_rec),
		.empty    (q_empty)
	);

	ltcd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_rec   (pop_rec),
		.q_pop   (q_pop),
		.result  (result)
	);

endmodule

`default_nettype wire

// ----- rtl/ltcd_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ltcd_front
// Classifies intervals, assembles biphase-mark bits into the 80-bit frame,
// checks sync and captures the BCD time fields of a completed frame.
// ----------------------------------------------------------------------------
module ltcd_front import ltcd_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	ltcd_in_if.sink        interval,
	input  wire cfg_regs_t cfg_regs,
	input  wire logic      q_full,
	output logic           q_push,
	output rec_t           q_rec
);

	localparam logic [POS_W-1:0] POS_FULL = POS_W'(FRAME_BITS);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BITS - 1);

	logic [FRAME_BITS-1:0] frame_q, frame_w, frame_n;
	logic [POS_W-1:0]      pos_q, pos_w, pos_n;
	logic                  half_q, half_n;
	logic                  is_short, put_en, put_val;
	logic                  full, sync_ok, accept;

	// units digit plus tens digit times ten
	function automatic logic [6:0] bcd_val(input logic [3:0] units, input logic [2:0] tens);
		return 7'(units) + {1'b0, tens, 3'b000} + {3'b000, tens, 1'b0};
	endfunction

	assign interval.ready = !q_full;
	assign accept         = interval.valid && !q_full;

	// half-bit classification
	always_comb begin
		is_short = interval.interval_ticks < cfg_regs.long_threshold;
		put_en   = 1'b0;
		put_val  = 1'b0;
		pos_w    = pos_q;
		half_n   = half_q;
		priority if (is_short && !half_q) begin
			put_en = 1'b1;
			pos_w  = pos_q + 1'b1;
		end else if (is_short) begin
			// short after a lone long half: step back, drop the half
			pos_w  = (pos_q != '0) ? pos_q - 1'b1 : pos_q;
			half_n = 1'b0;
		end else if (half_q) begin
			put_en  = 1'b1;
			put_val = 1'b1;
			pos_w   = pos_q + 1'b1;
			half_n  = 1'b0;
		end else begin
			half_n = 1'b1;
		end
	end

	// bit insert and sync check
	always_comb begin
		frame_w = frame_q;
		if (put_en) begin
			frame_w[pos_q] = put_val;
		end
		full    = (pos_w == POS_FULL);
		sync_ok = (frame_w[FRAME_BITS-1:SYNC_LSB] == cfg_regs.sync_key);
		frame_n = frame_w;
		pos_n   = pos_w;
		if (full && sync_ok) begin
			pos_n = '0;
		end else if (full) begin
			// slip by one bit and wait for the next bit to realign
			frame_n = {1'b0, frame_w[FRAME_BITS-1:1]};
			pos_n   = POS_LAST;
		end
	end

	// time fields of the completed frame
	always_comb begin
		q_push            = accept;
		q_rec.done        = full && sync_ok;
		q_rec.t.frames    = FRM_W'(bcd_val(frame_w[3:0], {1'b0, frame_w[9:8]}));
		q_rec.t.seconds   = SEC_W'(bcd_val(frame_w[19:16], frame_w[26:24]));
		q_rec.t.minutes   = MIN_W'(bcd_val(frame_w[35:32], frame_w[42:40]));
		q_rec.t.hours     = HOURS_W'(bcd_val(frame_w[51:48], {1'b0, frame_w[57:56]}));
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
			pos_q   <= '0;
			half_q  <= 1'b0;
		end else if (accept) begin
			frame_q <= frame_n;
			pos_q   <= pos_n;
			half_q  <= half_n;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/ltcd_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ltcd_queue
// Small FIFO of front words between the front and the back.
// ----------------------------------------------------------------------------
module ltcd_queue import ltcd_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire rec_t push_rec,
	output logic      full,
	input  wire logic pop,
	output rec_t      pop_rec,
	output logic      empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	rec_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_FULL);
	assign empty   = (count_q == '0);
	assign pop_rec = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/ltcd_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ltcd_back
// Converts decoded times to milliseconds, applies the 0..1000 ms acceptance
// window against the stored time and drives the result register.
// ----------------------------------------------------------------------------
module ltcd_back import ltcd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_empty,
	input  wire rec_t q_rec,
	output logic      q_pop,
	ltcd_out_if.source result
);

	localparam int MS_W = 28;
	localparam logic [MS_W-1:0] MS_PER_HOUR = 28'd3600000;
	localparam logic [MS_W-1:0] MS_PER_MIN  = 28'd60000;
	localparam logic [MS_W-1:0] MS_PER_SEC  = 28'd1000;
	localparam logic [MS_W:0]   WINDOW_MS   = 29'd1000;
	localparam int FD_W = FRM_W + 1;
	// frames * 125 / 3 == frames * 1000 / 24; /3 by reciprocal multiply
	localparam logic [6:0]  FRM_SCALE = 7'd125;
	localparam logic [14:0] RECIP3    = 15'd21846;

	rec_t             s1_rec;
	logic [MS_W-1:0]  s1_ms, new_ms;
	logic             s1_valid_q, out_valid_q, adv;
	time_t            stored_q;
	logic [MS_W-1:0]  stored_ms_q;
	logic             oow_q;
	logic             done_q, updated_q;

	logic signed [MS_W:0]   hms_diff;
	logic signed [FD_W-1:0] fdiff;
	logic [FD_W-1:0]        fmag;
	logic [13:0]            fprod;
	logic [28:0]            fquot;
	logic [11:0]            fms;
	logic signed [13:0]     fterm;
	logic signed [MS_W+1:0] diff;
	logic                   in_win, take;

	assign adv   = !out_valid_q || result.ready;
	assign q_pop = !q_empty && (!s1_valid_q || adv);

	// hours/minutes/seconds in ms of the incoming word
	assign new_ms = MS_W'(q_rec.t.hours) * MS_PER_HOUR
		+ MS_W'(q_rec.t.minutes) * MS_PER_MIN
		+ MS_W'(q_rec.t.seconds) * MS_PER_SEC;

	// window check: whole seconds part plus truncated frame term
	always_comb begin
		hms_diff = $signed({1'b0, s1_ms}) - $signed({1'b0, stored_ms_q});
		fdiff    = $signed({1'b0, s1_rec.t.frames}) - $signed({1'b0, stored_q.frames});
		fmag     = fdiff[FD_W-1] ? FD_W'(-fdiff) : FD_W'(fdiff);
		fprod    = 14'(fmag) * 14'(FRM_SCALE);
		fquot    = 29'(fprod) * 29'(RECIP3);
		fms      = fquot[27:16];
		fterm    = fdiff[FD_W-1] ? -$signed({2'b00, fms}) : $signed({2'b00, fms});
		diff     = (MS_W + 2)'(hms_diff) + (MS_W + 2)'(fterm);
		in_win   = !diff[MS_W+1] && (diff[MS_W:0] <= WINDOW_MS);
		take     = in_win || oow_q;
	end

	// decode stage and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			stored_q    <= '0;
			stored_ms_q <= '0;
			oow_q       <= 1'b0;
		end else begin
			if (q_pop) begin
				s1_valid_q <= 1'b1;
			end else if (adv) begin
				s1_valid_q <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= s1_valid_q;
				if (s1_valid_q && s1_rec.done) begin
					oow_q <= in_win ? 1'b0 : !oow_q;
					if (take) begin
						stored_q    <= s1_rec.t;
						stored_ms_q <= s1_ms;
					end
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			s1_rec <= q_rec;
			s1_ms  <= new_ms;
		end
		if (adv && s1_valid_q) begin
			done_q    <= s1_rec.done;
			updated_q <= s1_rec.done && take;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.frame_done   = done_q;
	assign result.time_updated = updated_q;
	assign result.hours_now    = stored_q.hours;
	assign result.minutes_now  = stored_q.minutes;
	assign result.seconds_now  = stored_q.seconds;
	assign result.frames_now   = stored_q.frames;

endmodule

`default_nettype wire

// ----- rtl/ltcd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ltcd_checker
// Port-level checks on the result channel of the timecode decoder.
// ----------------------------------------------------------------------------
`include "ltc_timecode_decoder_unit_macros.svh"

module ltcd_checker import ltcd_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic               frame_done,
	input wire logic               time_updated,
	input wire logic [HOURS_W-1:0] hours_now,
	input wire logic [MIN_W-1:0]   minutes_now,
	input wire logic [SEC_W-1:0]   seconds_now,
	input wire logic [FRM_W-1:0]   frames_now
);

	// a stalled result keeps its word
	`LTCD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable({frame_done, time_updated, hours_now, minutes_now, seconds_now, frames_now}))

	// the time is only replaced by a frame that passed sync
	`LTCD_ASSERT_IMPL(a_update_needs_frame, clk, arst_n, out_valid && time_updated, frame_done)

	// stored time stays within what the BCD decode can give
	`LTCD_ASSERT_IMPL(a_time_range, clk, arst_n, out_valid, (hours_now <= 6'd45) && (minutes_now <= 7'd85) && (seconds_now <= 7'd85) && (frames_now <= 6'd45))

	// nothing is offered straight out of reset
	`LTCD_ASSERT_IMPL(a_reset_idle, clk, arst_n, $rose(arst_n), !out_valid)

endmodule

bind ltc_timecode_decoder_unit ltcd_checker u_ltcd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.frame_done   (result.frame_done),
	.time_updated (result.time_updated),
	.hours_now    (result.hours_now),
	.minutes_now  (result.minutes_now),
	.seconds_now  (result.seconds_now),
	.frames_now   (result.frames_now)
);

`default_nettype wire

// ----- dv/ltcd_decoder_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltcd_decoder_checker
// Watches the interval, result and register channels of the timecode decoder.
// Every accepted interval word is run through a cycle-free model of the bit,
// frame and time-window logic. Every accepted result word is compared field
// by field against the oldest prediction.
// ----------------------------------------------------------------------------
module ltcd_decoder_checker import ltcd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	ltcd_in_if        interval,
	ltcd_out_if       result,
	ltcd_cfg_if       cfg,
	output int        fail_count,
	output int        words_in_flight
);

	typedef struct packed {
		logic               frame_done;
		logic               time_updated;
		logic [HOURS_W-1:0] hours;
		logic [MIN_W-1:0]   minutes;
		logic [SEC_W-1:0]   seconds;
		logic [FRM_W-1:0]   frames;
	} tc_result_t;

	tc_result_t            decoded_q[$];

	// register copies
	logic [CFG_DATA_W-1:0] long_thr;
	logic [CFG_DATA_W-1:0] sync_word;

	// decoder state
	logic [FRAME_BITS-1:0] frame_bits;
	logic [POS_W-1:0]      bit_idx;
	logic                  half_long;
	logic                  outside_pending;
	time_t                 held_tc;

	// unit nibble plus tens field eight bits up; non-BCD digits kept as binary
	function automatic int digit_pair(input logic [FRAME_BITS-1:0] fb, input int lsb,
		input int tens_bits);
		int units;
		int tens;
		units = fb[lsb +: 4];
		tens  = fb[lsb + 8 +: 3] & ((1 << tens_bits) - 1);
		return units + tens * 10;
	endfunction

	task automatic decode_interval(input logic [TICK_W-1:0] ticks, output tc_result_t res);
		time_t  fresh;
		longint diff;
		logic   take;
		res = '0;

		// biphase mark: one short is a 0, two longs are a 1
		if (ticks < long_thr) begin
			if (!half_long) begin
				frame_bits[bit_idx] = 1'b0;
				bit_idx++;
			end else begin
				// short after a lone long: step back, saturating at zero
				if (bit_idx != '0)
					bit_idx--;
				half_long = 1'b0;
			end
		end else if (half_long) begin
			half_long = 1'b0;
			frame_bits[bit_idx] = 1'b1;
			bit_idx++;
		end else begin
			half_long = 1'b1;
		end

		// full frame: check sync, else slide by one bit
		if (bit_idx >= FRAME_BITS) begin
			if (frame_bits[SYNC_LSB +: 16] == sync_word) begin
				bit_idx = '0;
				res.frame_done = 1'b1;
				fresh.frames  = FRM_W'(digit_pair(frame_bits, 0, 2));
				fresh.seconds = SEC_W'(digit_pair(frame_bits, 16, 3));
				fresh.minutes = MIN_W'(digit_pair(frame_bits, 32, 3));
				fresh.hours   = HOURS_W'(digit_pair(frame_bits, 48, 2));
				diff = (longint'(fresh.hours) - longint'(held_tc.hours)) * 3600000
					+ (longint'(fresh.minutes) - longint'(held_tc.minutes)) * 60000
					+ (longint'(fresh.seconds) - longint'(held_tc.seconds)) * 1000
					+ ((longint'(fresh.frames) - longint'(held_tc.frames)) * 1000) / 24;
				// outside the window only the second such frame in a row is taken
				if (diff < 0 || diff > 1000) begin
					take = outside_pending;
					outside_pending = !outside_pending;
				end else begin
					take = 1'b1;
					outside_pending = 1'b0;
				end
				if (take)
					held_tc = fresh;
				res.time_updated = take;
			end else begin
				frame_bits = frame_bits >> 1;
				bit_idx = POS_W'(FRAME_BITS - 1);
			end
		end

		res.hours   = held_tc.hours;
		res.minutes = held_tc.minutes;
		res.seconds = held_tc.seconds;
		res.frames  = held_tc.frames;
	endtask

	function automatic int field_check(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		tc_result_t predicted;
		tc_result_t want;
		int         misses;
		if (!arst_n) begin
			long_thr        = LONG_THRESHOLD_RST;
			sync_word       = SYNC_KEY_RST;
			frame_bits      = '0;
			bit_idx         = '0;
			half_long       = 1'b0;
			outside_pending = 1'b0;
			held_tc         = '0;
			decoded_q.delete();
			fail_count      <= 0;
			words_in_flight <= 0;
		end else begin
			misses = 0;

			// register writes
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_LONG_THRESHOLD: long_thr = cfg.data;
					REG_SYNC_KEY:       sync_word = cfg.data;
					default: ;
				endcase
			end

			// new interval word
			if (interval.valid && interval.ready) begin
				decode_interval(interval.interval_ticks, predicted);
				decoded_q.push_back(predicted);
			end

			// result word against oldest prediction
			if (result.valid && result.ready) begin
				if (decoded_q.size() == 0) begin
					$error("result word with no interval word pending");
					misses++;
				end else begin
					want = decoded_q.pop_front();
					misses += field_check("frame_done", want.frame_done, result.frame_done);
					misses += field_check("time_updated", want.time_updated,
						result.time_updated);
					misses += field_check("hours_now", want.hours, result.hours_now);
					misses += field_check("minutes_now", want.minutes, result.minutes_now);
					misses += field_check("seconds_now", want.seconds, result.seconds_now);
					misses += field_check("frames_now", want.frames, result.frames_now);
				end
			end

			fail_count      <= fail_count + misses;
			words_in_flight <= decoded_q.size();
		end
	end

endmodule

// ----- dv/tb_ltc_timecode_decoder_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ltc_timecode_decoder_unit
// Drives edge intervals into the timecode decoder: a few hand-picked
// intervals, then biphase-encoded frames carrying a running timecode, mixed
// with damaged frames and noise. Runs through several threshold and sync
// settings and several idle/stall patterns; the checker does the comparing.
// ----------------------------------------------------------------------------
module tb_ltc_timecode_decoder_unit;
	import ltcd_pkg::*;

	logic                  clk;
	logic                  arst_n;
	int                    fail_count;
	int                    words_in_flight;
	int                    sender_idle_pct;
	int                    receiver_stall_pct;
	int                    words_sent;
	logic [CFG_DATA_W-1:0] cur_thr;
	logic [CFG_DATA_W-1:0] cur_key;

	// timecode carried by the generated frames
	int                    src_h;
	int                    src_m;
	int                    src_s;
	int                    src_f;

	ltcd_in_if  interval_ch ();
	ltcd_out_if result_ch ();
	ltcd_cfg_if cfg_ch ();

	ltc_timecode_decoder_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.interval (interval_ch),
		.result   (result_ch),
		.cfg      (cfg_ch)
	);

	ltcd_decoder_checker tc_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.interval        (interval_ch),
		.result          (result_ch),
		.cfg             (cfg_ch),
		.fail_count      (fail_count),
		.words_in_flight (words_in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side back-pressure
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			result_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	task automatic send_interval(input logic [TICK_W-1:0] ticks);
		while ($urandom_range(99) < sender_idle_pct) begin
			interval_ch.valid <= 1'b0;
			@(posedge clk);
		end
		interval_ch.valid          <= 1'b1;
		interval_ch.interval_ticks <= ticks;
		do @(posedge clk); while (!interval_ch.ready);
		words_sent++;
	endtask

	task automatic stop_and_drain();
		interval_ch.valid <= 1'b0;
		do @(posedge clk); while (words_in_flight != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		stop_and_drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == REG_LONG_THRESHOLD)
			cur_thr = val;
		else
			cur_key = val;
	endtask

	// interval lengths, leaning on the threshold edges
	function automatic logic [TICK_W-1:0] long_ticks();
		int r;
		r = $urandom_range(7);
		if (r == 0)
			return cur_thr;
		if (r == 1)
			return '1;
		return TICK_W'($urandom_range(65535, cur_thr));
	endfunction

	function automatic logic [TICK_W-1:0] short_ticks();
		int r;
		r = $urandom_range(7);
		// nothing is short at a zero threshold
		if (cur_thr == '0)
			return long_ticks();
		if (r == 0)
			return '0;
		if (r == 1)
			return cur_thr - 1'b1;
		return TICK_W'($urandom_range(cur_thr - 1, 0));
	endfunction

	task automatic send_bit(input logic b);
		if (b) begin
			send_interval(long_ticks());
			send_interval(long_ticks());
		end else begin
			send_interval(short_ticks());
		end
	endtask

	task automatic advance_time(input int n);
		src_f += n;
		while (src_f >= 24) begin
			src_f -= 24;
			src_s++;
		end
		if (src_s >= 60) begin
			src_s = 0;
			src_m++;
		end
		if (src_m >= 60) begin
			src_m = 0;
			src_h = (src_h + 1) % 24;
		end
	endtask

	// 80-bit frame: random user bits, BCD time unless raw digits wanted
	function automatic logic [FRAME_BITS-1:0] build_frame(input logic [15:0] key,
		input bit raw_digits);
		logic [FRAME_BITS-1:0] fb;
		fb[31:0]  = $urandom;
		fb[63:32] = $urandom;
		fb[SYNC_LSB +: 16] = key;
		if (!raw_digits) begin
			fb[3:0]   = 4'(src_f % 10);
			fb[9:8]   = 2'(src_f / 10);
			fb[19:16] = 4'(src_s % 10);
			fb[26:24] = 3'(src_s / 10);
			fb[35:32] = 4'(src_m % 10);
			fb[42:40] = 3'(src_m / 10);
			fb[51:48] = 4'(src_h % 10);
			fb[57:56] = 2'(src_h / 10);
		end
		return fb;
	endfunction

	// damage kinds: 0 bad half inserted, 1 cut short, 2 wrong sync
	task automatic send_frame(input bit broken);
		logic [FRAME_BITS-1:0] fb;
		int                    r;
		int                    cut;
		int                    kind;
		bit                    raw;
		r   = $urandom_range(99);
		raw = 1'b0;
		if (r < 60) begin
			advance_time(1);
		end else if (r < 70) begin
			// zero to just past one second, around the window edge
			advance_time($urandom_range(26));
		end else if (r < 80) begin
			src_h = $urandom_range(23);
			src_m = $urandom_range(59);
			src_s = $urandom_range(59);
			src_f = $urandom_range(23);
		end else if (r < 88) begin
			raw = 1'b1;
		end else begin
			// backwards in time
			src_s = (src_s + 59) % 60;
		end
		fb   = build_frame(cur_key, raw);
		kind = broken ? $urandom_range(2) : 3;
		cut  = $urandom_range(FRAME_BITS - 1);
		if (kind == 2)
			fb[SYNC_LSB +: 16] = fb[SYNC_LSB +: 16] ^ 16'($urandom_range(65535, 1));
		for (int i = 0; i < FRAME_BITS; i++) begin
			if (i == cut && kind == 1)
				break;
			if (i == cut && kind == 0) begin
				send_interval(long_ticks());
				send_interval(short_ticks());
			end
			send_bit(fb[i]);
		end
	endtask

	task automatic noise_burst();
		int n;
		n = $urandom_range(30, 1);
		repeat (n) begin
			if ($urandom_range(3) == 0) begin
				send_interval(long_ticks());
				send_interval(short_ticks());
			end else begin
				send_interval(TICK_W'($urandom_range(65535)));
			end
		end
	endtask

	task automatic run_phase(input int snd, input int rcv, input int budget);
		int start;
		int r;
		start              = words_sent;
		sender_idle_pct    = snd;
		receiver_stall_pct = rcv;
		while (words_sent - start < budget) begin
			r = $urandom_range(99);
			if (r < 75)
				send_frame(1'b0);
			else if (r < 87)
				send_frame(1'b1);
			else
				noise_burst();
			if ($urandom_range(15) == 0)
				stop_and_drain();
		end
	endtask

	// hand-picked intervals at the default threshold of 78
	logic [TICK_W-1:0] edge_words [14] = '{
		16'hFFFF, 16'h0000,           // lone long then short at bit zero
		16'h0000, 16'd77,             // zeros, just under threshold
		16'd78, 16'd78,               // one, right at threshold
		16'hFFFF, 16'h0001,           // lone long then short mid-frame
		16'h5555, 16'hAAAA,
		16'h00FF, 16'hFF00,
		16'h0F0F, 16'hF0F0
	};

	initial begin
		interval_ch.valid          <= 1'b0;
		interval_ch.interval_ticks <= '0;
		cfg_ch.valid               <= 1'b0;
		cfg_ch.index               <= REG_LONG_THRESHOLD;
		cfg_ch.data                <= '0;
		arst_n                     <= 1'b0;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		words_sent         = 0;
		cur_thr            = LONG_THRESHOLD_RST;
		cur_key            = SYNC_KEY_RST;
		src_h              = 10;
		src_m              = 0;
		src_s              = 0;
		src_f              = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (edge_words[i])
			send_interval(edge_words[i]);
		run_phase(0, 0, 110);

		// mid threshold, random sync; one full drain with the sender held off
		write_reg(REG_LONG_THRESHOLD, 16'($urandom_range(200, 20)));
		write_reg(REG_SYNC_KEY, 16'($urandom));
		sender_idle_pct = 86;
		send_frame(1'b0);
		stop_and_drain();
		run_phase(86, 0, 120);

		// almost everything short
		write_reg(REG_LONG_THRESHOLD, 16'hFFFF);
		write_reg(REG_SYNC_KEY, 16'h0000);
		run_phase(0, 86, 90);

		// everything long: all-ones frames
		write_reg(REG_LONG_THRESHOLD, 16'h0000);
		write_reg(REG_SYNC_KEY, 16'hFFFF);
		run_phase(32, 32, 90);

		// only zero is short
		write_reg(REG_LONG_THRESHOLD, 16'h0001);
		write_reg(REG_SYNC_KEY, 16'($urandom));
		run_phase(0, 0, 70);

		write_reg(REG_LONG_THRESHOLD, 16'($urandom_range(300, 30)));
		write_reg(REG_SYNC_KEY, SYNC_KEY_RST);
		run_phase(32, 32, 110);

		stop_and_drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
